@@ rtl/bcq_pkg.sv @@
package bcq_pkg;

	// Datapath widths: doubled coordinates, clip terms and products.
	localparam int COORD_W = 24;
	localparam int SIZE_W  = 16;
	localparam int CFG_W   = 7;
	localparam int CW      = 28;
	localparam int PW      = 2 * CW;

	// Operation codes.
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_CIRCLE  = 2'd1;
	localparam logic [1:0] OP_SEGMENT = 2'd2;

	// Configuration register indexes.
	localparam logic REG_COLLIDER = 1'b0;
	localparam logic REG_WALL     = 1'b1;

	// One command.
	typedef struct packed {
		logic [1:0]                opcode;
		logic [5:0]                entry_index;
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_z;
		logic [SIZE_W-1:0]         radius;
		logic [SIZE_W-1:0]         size_w;
		logic [SIZE_W-1:0]         size_d;
		logic                      box_active;
	} cmd_t;

	// One result.
	typedef struct packed {
		logic       hit;
		logic [1:0] op_done;
	} result_t;

	// One table entry.
	typedef struct packed {
		logic                      en;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cz;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         d;
	} box_t;

	// Accumulator control of the shared multiplier.
	typedef struct packed {
		logic acc_load;
		logic acc_add;
	} mul_ctrl_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_BOX,
		ST_C0,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_S0,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_S4,
		ST_DONE
	} state_t;

endpackage

@@ rtl/bcq_box_mem.sv @@
module bcq_box_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  bcq_pkg::box_t      wdata,
	input  logic [AW-1:0]      raddr,
	output bcq_pkg::box_t      rdata
);

	bcq_pkg::box_t mem [0:DEPTH-1];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bcq_mul_unit.sv @@
module bcq_mul_unit (
	input  logic                            clk,
	input  logic signed [bcq_pkg::CW-1:0]   a,
	input  logic signed [bcq_pkg::CW-1:0]   b,
	input  bcq_pkg::mul_ctrl_t              ctrl,
	output logic signed [bcq_pkg::PW-1:0]   mul_q,
	output logic signed [bcq_pkg::PW-1:0]   acc_q
);

	// Registered signed product.
	always_ff @(posedge clk) begin
		mul_q <= a * b;
	end

	// Accumulator holds the previous product or a running sum of products.
	always_ff @(posedge clk) begin
		if (ctrl.acc_load) begin
			acc_q <= mul_q;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + mul_q;
		end
	end

endmodule

@@ rtl/box_collision_query_engine.sv @@
// Box collision query engine.
// A command is a transfer on start while busy is low; busy stays high until
// the command's single result has been shown. The result is shown on result
// for exactly one cycle with done high; the receiver cannot hold it off.
// Writes load one table slot (slots at or beyond MAX_BOXES are ignored).
// Circle queries test the leading slots counted by configuration register 0,
// segment queries those counted by register 1, both saturated to MAX_BOXES;
// a query stops at the first hit. Configuration writes go through
// cfg_we/cfg_index/cfg_wdata and take effect at once; they must be made only
// while the block is idle, which the block itself does not enforce.
// A write, an unused opcode or a zero box count goes straight to the result.
// A circle query fetches each box and, if it is enabled, compares its squared
// distance with the squared radius; a segment query fetches each box and clips
// it edge by edge: a parallel edge checks only its sign, another edge runs a
// reject compare, then a bound update compare, and a rejected edge ends the box.
// Busy is low again in the cycle after done, so the next command follows then.
// All clip ratio compares and squared distances go through one registered
// signed multiplier, one product per cycle, which sets the per-box cost.
// After reset the table is swept once, slot by slot, to clear the enable flags,
// with busy high; configuration writes are still taken meanwhile.
module box_collision_query_engine #(
	parameter int MAX_BOXES = 64,
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  bcq_pkg::cmd_t                 cmd,
	output logic                          busy,
	output logic                          done,
	output bcq_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bcq_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int AW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNTW   = $clog2(MAX_BOXES + 1);
	localparam int MARGIN = ((1 << FRAC_BITS) * 10 + 50) / 100;
	localparam int CW     = bcq_pkg::CW;
	localparam int PW     = bcq_pkg::PW;

	localparam logic signed [CW-1:0] MARGIN_C = CW'(MARGIN);

	bcq_pkg::state_t state_q, state_d;

	logic [CNTW-1:0]          box_idx_q, box_idx_d;
	logic [CNTW-1:0]          lim_q;
	logic [1:0]               op_q;
	logic                     hit_q, hit_d;
	logic [1:0]               edge_q, edge_d;
	logic [bcq_pkg::CFG_W-1:0] collider_q, wall_q;

	logic signed [bcq_pkg::COORD_W-1:0] ax_q, az_q;
	logic [bcq_pkg::SIZE_W-1:0]         rad_q;
	logic signed [CW-1:0]               dxs_q, dzs_q;
	logic signed [CW-1:0]               cdx_q, cdz_q;
	logic signed [CW-1:0]               q_q [0:3];
	logic signed [CW-1:0]               lo_n_q, lo_d_q, hi_n_q, hi_d_q;

	logic                     accept;
	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	bcq_pkg::box_t            mem_wdata;
	bcq_pkg::box_t            rd;
	logic [bcq_pkg::CFG_W-1:0] cnt_sel;
	logic [CNTW-1:0]          lim_c;
	logic [CNTW-1:0]          idx_nxt;
	logic                     idx_last;
	logic                     box_load;
	logic                     lo_upd, hi_upd;

	logic signed [CW-1:0]     ax2, az2, bx2, bz2, r2;
	logic signed [CW-1:0]     cx2, cz2, bw, bd;
	logic signed [CW-1:0]     xlo, xhi, zlo, zhi, xc, zc;
	logic signed [CW-1:0]     p, q, rn, rdn;
	logic                     p_neg;
	logic signed [CW-1:0]     mul_a, mul_b;
	bcq_pkg::mul_ctrl_t       mul_ctrl;
	logic signed [PW-1:0]     mul_q, acc_q;

	// Table storage.
	bcq_box_mem #(
		.DEPTH(MAX_BOXES),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(box_idx_q[AW-1:0]),
		.rdata(rd)
	);

	// Shared multiplier with accumulator.
	bcq_mul_unit u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.ctrl (mul_ctrl),
		.mul_q(mul_q),
		.acc_q(acc_q)
	);

	assign busy   = (state_q != bcq_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign done   = (state_q == bcq_pkg::ST_DONE);
	assign result = '{hit: hit_q, op_done: op_q};

	// Box count of the query, saturated to the table size.
	assign cnt_sel = (cmd.opcode == bcq_pkg::OP_CIRCLE) ? collider_q : wall_q;
	assign lim_c   = (32'(cnt_sel) > 32'(MAX_BOXES)) ? CNTW'(MAX_BOXES) : CNTW'(cnt_sel);
	assign idx_nxt = box_idx_q + CNTW'(1);
	assign idx_last = (idx_nxt == lim_q);

	// Doubled query coordinates; half sizes become exact.
	assign ax2 = CW'($signed({ax_q, 1'b0}));
	assign az2 = CW'($signed({az_q, 1'b0}));
	assign bx2 = CW'($signed({cmd.b_x, 1'b0}));
	assign bz2 = CW'($signed({cmd.b_z, 1'b0}));
	assign r2  = CW'({rad_q, 1'b0});

	// Box bounds from the registered table read.
	assign cx2 = CW'($signed({rd.cx, 1'b0}));
	assign cz2 = CW'($signed({rd.cz, 1'b0}));
	assign bw  = CW'(rd.w);
	assign bd  = CW'(rd.d);
	assign xlo = cx2 - bw;
	assign xhi = cx2 + bw;
	assign zlo = cz2 - bd;
	assign zhi = cz2 + bd;

	// Circle center clamped into the box.
	assign xc = (ax2 < xlo) ? xlo : ((ax2 > xhi) ? xhi : ax2);
	assign zc = (az2 < zlo) ? zlo : ((az2 > zhi) ? zhi : az2);

	// Current clip edge and its ratio rn/rdn with a non-negative denominator.
	always_comb begin
		case (edge_q)
			2'd0: p = -dxs_q;
			2'd1: p = dxs_q;
			2'd2: p = -dzs_q;
			2'd3: p = dzs_q;
			default: p = dxs_q;
		endcase
	end
	assign q     = q_q[edge_q];
	assign p_neg = p[CW-1];
	assign rn    = p_neg ? -q : q;
	assign rdn   = p_neg ? -p : p;

	// Sequencer: next state, multiplier operands and table writes.
	always_comb begin
		state_d   = state_q;
		box_idx_d = box_idx_q;
		hit_d     = hit_q;
		edge_d    = edge_q;
		box_load  = 1'b0;
		lo_upd    = 1'b0;
		hi_upd    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = box_idx_q[AW-1:0];
		mem_wdata = '0;
		mul_a     = rn;
		mul_b     = rdn;
		mul_ctrl  = '{acc_load: 1'b0, acc_add: 1'b0};
		case (state_q)
			bcq_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (32'(box_idx_q) == 32'(MAX_BOXES - 1)) begin
					box_idx_d = '0;
					state_d   = bcq_pkg::ST_IDLE;
				end else begin
					box_idx_d = idx_nxt;
				end
			end
			bcq_pkg::ST_IDLE: begin
				if (accept) begin
					hit_d     = 1'b0;
					box_idx_d = '0;
					case (cmd.opcode)
						bcq_pkg::OP_WRITE: begin
							mem_we    = (32'(cmd.entry_index) < 32'(MAX_BOXES));
							mem_waddr = AW'(cmd.entry_index);
							mem_wdata = '{en: cmd.box_active, cx: cmd.a_x, cz: cmd.a_z,
								w: cmd.size_w, d: cmd.size_d};
							state_d   = bcq_pkg::ST_DONE;
						end
						bcq_pkg::OP_CIRCLE, bcq_pkg::OP_SEGMENT: begin
							state_d = (lim_c == '0) ? bcq_pkg::ST_DONE : bcq_pkg::ST_FETCH;
						end
						default: state_d = bcq_pkg::ST_DONE;
					endcase
				end
			end
			bcq_pkg::ST_FETCH: begin
				state_d = bcq_pkg::ST_BOX;
			end
			bcq_pkg::ST_BOX: begin
				if (!rd.en) begin
					box_idx_d = idx_nxt;
					state_d   = idx_last ? bcq_pkg::ST_DONE : bcq_pkg::ST_FETCH;
				end else begin
					box_load = 1'b1;
					edge_d   = 2'd0;
					state_d  = (op_q == bcq_pkg::OP_CIRCLE) ? bcq_pkg::ST_C0 : bcq_pkg::ST_S0;
				end
			end
			// Squared distance against squared radius.
			bcq_pkg::ST_C0: begin
				mul_a   = cdx_q;
				mul_b   = cdx_q;
				state_d = bcq_pkg::ST_C1;
			end
			bcq_pkg::ST_C1: begin
				mul_a    = cdz_q;
				mul_b    = cdz_q;
				mul_ctrl = '{acc_load: 1'b1, acc_add: 1'b0};
				state_d  = bcq_pkg::ST_C2;
			end
			bcq_pkg::ST_C2: begin
				mul_a    = r2;
				mul_b    = r2;
				mul_ctrl = '{acc_load: 1'b0, acc_add: 1'b1};
				state_d  = bcq_pkg::ST_C3;
			end
			bcq_pkg::ST_C3: begin
				if (acc_q < mul_q) begin
					hit_d   = 1'b1;
					state_d = bcq_pkg::ST_DONE;
				end else begin
					box_idx_d = idx_nxt;
					state_d   = idx_last ? bcq_pkg::ST_DONE : bcq_pkg::ST_FETCH;
				end
			end
			// Clip edge: a parallel edge checks only its sign; otherwise reject compare, then bound update compare.
			bcq_pkg::ST_S0: begin
				mul_a = rn;
				mul_b = p_neg ? hi_d_q : lo_d_q;
				if (p == '0) begin
					if (q < 0) begin
						box_idx_d = idx_nxt;
						state_d   = idx_last ? bcq_pkg::ST_DONE : bcq_pkg::ST_FETCH;
					end else if (edge_q == 2'd3) begin
						hit_d   = 1'b1;
						state_d = bcq_pkg::ST_DONE;
					end else begin
						edge_d = edge_q + 2'd1;
					end
				end else begin
					state_d = bcq_pkg::ST_S1;
				end
			end
			bcq_pkg::ST_S1: begin
				mul_a    = p_neg ? hi_n_q : lo_n_q;
				mul_b    = rdn;
				mul_ctrl = '{acc_load: 1'b1, acc_add: 1'b0};
				state_d  = bcq_pkg::ST_S2;
			end
			bcq_pkg::ST_S2: begin
				mul_a = rn;
				mul_b = p_neg ? lo_d_q : hi_d_q;
				if (p_neg ? (acc_q > mul_q) : (acc_q < mul_q)) begin
					box_idx_d = idx_nxt;
					state_d   = idx_last ? bcq_pkg::ST_DONE : bcq_pkg::ST_FETCH;
				end else begin
					state_d = bcq_pkg::ST_S3;
				end
			end
			bcq_pkg::ST_S3: begin
				mul_a    = p_neg ? lo_n_q : hi_n_q;
				mul_b    = rdn;
				mul_ctrl = '{acc_load: 1'b1, acc_add: 1'b0};
				state_d  = bcq_pkg::ST_S4;
			end
			bcq_pkg::ST_S4: begin
				lo_upd = p_neg && (acc_q > mul_q);
				hi_upd = !p_neg && (acc_q < mul_q);
				if (edge_q == 2'd3) begin
					hit_d   = 1'b1;
					state_d = bcq_pkg::ST_DONE;
				end else begin
					edge_d  = edge_q + 2'd1;
					state_d = bcq_pkg::ST_S0;
				end
			end
			bcq_pkg::ST_DONE: begin
				state_d = bcq_pkg::ST_IDLE;
			end
			default: state_d = bcq_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bcq_pkg::ST_CLEAR;
			box_idx_q <= '0;
			hit_q     <= 1'b0;
			edge_q    <= 2'd0;
		end else begin
			state_q   <= state_d;
			box_idx_q <= box_idx_d;
			hit_q     <= hit_d;
			edge_q    <= edge_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collider_q <= '0;
			wall_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bcq_pkg::REG_COLLIDER: collider_q <= cfg_wdata;
				bcq_pkg::REG_WALL:     wall_q     <= cfg_wdata;
				default:               wall_q     <= wall_q;
			endcase
		end
	end

	// Query operands captured on the start transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.opcode;
			lim_q <= lim_c;
			ax_q  <= cmd.a_x;
			az_q  <= cmd.a_z;
			rad_q <= cmd.radius;
			dxs_q <= bx2 - CW'($signed({cmd.a_x, 1'b0}));
			dzs_q <= bz2 - CW'($signed({cmd.a_z, 1'b0}));
		end
	end

	// Per-box terms and the running clip window.
	always_ff @(posedge clk) begin
		if (box_load) begin
			cdx_q  <= ax2 - xc;
			cdz_q  <= az2 - zc;
			q_q[0] <= ax2 - (xlo - MARGIN_C);
			q_q[1] <= (xhi + MARGIN_C) - ax2;
			q_q[2] <= az2 - (zlo - MARGIN_C);
			q_q[3] <= (zhi + MARGIN_C) - az2;
			lo_n_q <= CW'(0);
			lo_d_q <= CW'(1);
			hi_n_q <= CW'(1);
			hi_d_q <= CW'(1);
		end else begin
			if (lo_upd) begin
				lo_n_q <= rn;
				lo_d_q <= rdn;
			end
			if (hi_upd) begin
				hi_n_q <= rn;
				hi_d_q <= rdn;
			end
		end
	end

endmodule
